// ===== design/emi_pkg.sv =====
// ----------------------------------------------------------------------------
// emi_pkg
// Shared types, register codes and constants of the EEPROM mailbox window.
// ----------------------------------------------------------------------------
`default_nettype none

package emi_pkg;

    localparam int BANK_COUNT_DEF     = 8;
    localparam int BYTES_PER_BANK_DEF = 256;

    localparam logic [7:0] OPC_SET_BANK = 8'h42;
    localparam logic [7:0] OPC_READ     = 8'h4E;
    localparam logic [7:0] OPC_WRITE    = 8'h4D;

    localparam int CTL_PROCESSING_BIT = 0;
    localparam int CTL_START_BIT      = 1;

    localparam logic [7:0] ERASED = 8'hFF;

    localparam logic [15:0] RST_WINDOW_BASE = 16'hFD60;
    localparam logic [2:0]  RST_HIGH_OFFSET = 3'd1;
    localparam logic [2:0]  RST_LOW_OFFSET  = 3'd2;
    localparam logic [2:0]  RST_DATA_OFFSET = 3'd3;
    localparam logic [15:0] RST_CTL_ADDR    = 16'hF982;
    localparam logic [15:0] RST_OPC_ADDR    = 16'hF98C;
    localparam logic [15:0] RST_PARAM_ADDR  = 16'hF98D;
    localparam logic [15:0] RST_RET_ADDR    = 16'hF983;

    typedef enum logic [2:0] {
        REG_WINDOW_BASE = 3'd0,
        REG_HIGH_OFFSET = 3'd1,
        REG_LOW_OFFSET  = 3'd2,
        REG_DATA_OFFSET = 3'd3,
        REG_CTL_ADDR    = 3'd4,
        REG_OPC_ADDR    = 3'd5,
        REG_PARAM_ADDR  = 3'd6,
        REG_RET_ADDR    = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PORT_NONE = 2'd0,
        PORT_HIGH = 2'd1,
        PORT_LOW  = 2'd2,
        PORT_DATA = 2'd3
    } t_port_sel;

    typedef struct packed {
        logic [15:0] window_base;
        logic [2:0]  high_offset;
        logic [2:0]  low_offset;
        logic [2:0]  data_offset;
        logic [15:0] ctl_addr;
        logic [15:0] opc_addr;
        logic [15:0] param_addr;
        logic [15:0] ret_addr;
    } t_cfg;

    typedef struct packed {
        logic      valid;
        logic      is_read;
        t_port_sel port;
        logic [7:0] wdata;
    } t_access;

    typedef struct packed {
        logic [7:0] rdata;
        logic       done;
    } t_mbx_resp;

    typedef logic [7:0] t_byte_lut [256];

    // Byte offset inside a bank, built at elaboration by repeated subtraction.
    function automatic t_byte_lut build_offset_lut(int bank_bytes);
        t_byte_lut lut;
        int        rem;
        for (int i = 0; i < 256; i++) begin
            rem = i;
            for (int k = 0; k < 16; k++) begin
                if (rem >= bank_bytes) begin
                    rem = rem - bank_bytes;
                end
            end
            lut[i] = 8'(rem);
        end
        return lut;
    endfunction

endpackage

`default_nettype wire

// ===== design/emi_in_if.sv =====
// ----------------------------------------------------------------------------
// emi_in_if
// Bus access channel: one word is one host read or write.
// ----------------------------------------------------------------------------
`default_nettype none

interface emi_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] io_port;
    logic [7:0]  write_data;

    modport source (output valid, output op, output io_port, output write_data,
                    input ready);
    modport sink   (input valid, input op, input io_port, input write_data,
                    output ready);
endinterface

`default_nettype wire

// ===== design/emi_out_if.sv =====
// ----------------------------------------------------------------------------
// emi_out_if
// Result channel: one word per bus access.
// ----------------------------------------------------------------------------
`default_nettype none

interface emi_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       port_selected;
    logic       command_done;

    modport source (output valid, output read_data, output port_selected,
                    output command_done, input ready);
    modport sink   (input valid, input read_data, input port_selected,
                    input command_done, output ready);
endinterface

`default_nettype wire

// ===== design/emi_ram.sv =====
// ----------------------------------------------------------------------------
// emi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module emi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/emi_decode.sv =====
// ----------------------------------------------------------------------------
// emi_decode
// Window port decode: high index, low index or data port, in that priority.
// ----------------------------------------------------------------------------
`default_nettype none

module emi_decode (
    input  wire emi_pkg::t_cfg      i_cfg,
    input  wire logic [15:0]        i_io_port,
    output      emi_pkg::t_port_sel o_port
);

    logic [15:0] high_port;
    logic [15:0] low_port;
    logic [15:0] data_port;

    assign high_port = i_cfg.window_base + 16'(i_cfg.high_offset);
    assign low_port  = i_cfg.window_base + 16'(i_cfg.low_offset);
    assign data_port = i_cfg.window_base + 16'(i_cfg.data_offset);

    always_comb begin
        if (i_io_port == high_port) begin
            o_port = emi_pkg::PORT_HIGH;
        end else if (i_io_port == low_port) begin
            o_port = emi_pkg::PORT_LOW;
        end else if (i_io_port == data_port) begin
            o_port = emi_pkg::PORT_DATA;
        end else begin
            o_port = emi_pkg::PORT_NONE;
        end
    end

endmodule

`default_nettype wire

// ===== design/emi_mailbox.sv =====
// ----------------------------------------------------------------------------
// emi_mailbox
// RAM index, mailbox bytes, command execution and the EEPROM array with its
// erase pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module emi_mailbox #(
    parameter int BANK_COUNT     = emi_pkg::BANK_COUNT_DEF,
    parameter int BYTES_PER_BANK = emi_pkg::BYTES_PER_BANK_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire emi_pkg::t_cfg      i_cfg,
    input  wire emi_pkg::t_access   i_acc,
    output      emi_pkg::t_mbx_resp o_resp,
    output      logic               o_busy
);

    localparam int DEPTH = BANK_COUNT * BYTES_PER_BANK;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

    localparam logic [AW-1:0]  LAST_ADDR  = AW'(DEPTH - 1);
    localparam logic [AW-1:0]  BANK_BYTES = AW'(BYTES_PER_BANK);
    localparam logic [8:0]     BANK_LIMIT = 9'(BANK_COUNT);
    localparam logic [7:0]     START_MASK = 8'(1 << emi_pkg::CTL_START_BIT);
    localparam emi_pkg::t_byte_lut OFFSET_LUT = emi_pkg::build_offset_lut(BYTES_PER_BANK);

    logic [15:0]   r_index, n_index;
    logic [7:0]    r_ctl, n_ctl;
    logic [7:0]    r_opc, n_opc;
    logic [7:0]    r_p0, n_p0;
    logic [7:0]    r_p1, n_p1;
    logic [7:0]    r_ret, n_ret;
    logic [BW-1:0] r_bank, n_bank;
    logic          r_rd_pend, n_rd_pend;
    logic          r_busy, n_busy;
    logic [AW-1:0] r_clr_addr, n_clr_addr;

    logic [15:0]   p1_addr;
    logic          hit_ctl, hit_opc, hit_p0, hit_p1, hit_ret;
    logic [7:0]    ret_now;
    logic [7:0]    mbx_rdata;
    logic          wr_data;
    logic          start;
    logic          rd_cmd;
    logic          wr_cmd;
    logic [AW-1:0] ee_addr;
    logic [AW-1:0] bank_ext;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    assign p1_addr  = i_cfg.param_addr + 16'd1;
    assign hit_ctl  = (r_index == i_cfg.ctl_addr);
    assign hit_opc  = !hit_ctl && (r_index == i_cfg.opc_addr);
    assign hit_p0   = !hit_ctl && !hit_opc && (r_index == i_cfg.param_addr);
    assign hit_p1   = !hit_ctl && !hit_opc && !hit_p0 && (r_index == p1_addr);
    assign hit_ret  = !hit_ctl && !hit_opc && !hit_p0 && !hit_p1
                      && (r_index == i_cfg.ret_addr);

    assign ret_now  = r_rd_pend ? ram_rdata : r_ret;

    assign bank_ext = AW'(r_bank);
    assign ee_addr  = AW'(bank_ext * BANK_BYTES) + AW'(OFFSET_LUT[r_p0]);

    assign wr_data  = i_acc.valid && !i_acc.is_read && (i_acc.port == emi_pkg::PORT_DATA);
    assign start    = wr_data && hit_ctl && i_acc.wdata[emi_pkg::CTL_START_BIT];
    assign rd_cmd   = start && (r_opc == emi_pkg::OPC_READ);
    assign wr_cmd   = start && (r_opc == emi_pkg::OPC_WRITE);

    always_comb begin
        if (hit_ctl) begin
            mbx_rdata = r_ctl;
        end else if (hit_opc) begin
            mbx_rdata = r_opc;
        end else if (hit_p0) begin
            mbx_rdata = r_p0;
        end else if (hit_p1) begin
            mbx_rdata = r_p1;
        end else if (hit_ret) begin
            mbx_rdata = ret_now;
        end else begin
            mbx_rdata = 8'd0;
        end
    end

    always_comb begin
        o_resp.rdata = 8'd0;
        o_resp.done  = start;
        if (i_acc.is_read) begin
            case (i_acc.port)
                emi_pkg::PORT_HIGH: o_resp.rdata = r_index[15:8];
                emi_pkg::PORT_LOW:  o_resp.rdata = r_index[7:0];
                emi_pkg::PORT_DATA: o_resp.rdata = mbx_rdata;
                default:            o_resp.rdata = 8'd0;
            endcase
        end
    end

    always_comb begin
        n_index   = r_index;
        n_ctl     = r_ctl;
        n_opc     = r_opc;
        n_p0      = r_p0;
        n_p1      = r_p1;
        n_ret     = ret_now;
        n_bank    = r_bank;
        n_rd_pend = rd_cmd;
        if (i_acc.valid && !i_acc.is_read) begin
            case (i_acc.port)
                emi_pkg::PORT_HIGH: n_index = {i_acc.wdata, r_index[7:0]};
                emi_pkg::PORT_LOW:  n_index = {r_index[15:8], i_acc.wdata};
                emi_pkg::PORT_DATA: begin
                    if (hit_ctl) begin
                        n_ctl = start ? (i_acc.wdata & ~START_MASK) : i_acc.wdata;
                    end else if (hit_opc) begin
                        n_opc = i_acc.wdata;
                    end else if (hit_p0) begin
                        n_p0 = i_acc.wdata;
                    end else if (hit_p1) begin
                        n_p1 = i_acc.wdata;
                    end else if (hit_ret) begin
                        n_ret = i_acc.wdata;
                    end
                end
                default: n_index = r_index;
            endcase
        end
        if (start && (r_opc == emi_pkg::OPC_SET_BANK) && ({1'b0, r_p0} < BANK_LIMIT)) begin
            n_bank = r_p0[BW-1:0];
        end
    end

    always_comb begin
        n_busy     = r_busy;
        n_clr_addr = r_clr_addr;
        if (r_busy) begin
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                n_busy = 1'b0;
            end
        end
    end

    always_comb begin
        ram_we    = r_busy || wr_cmd;
        ram_waddr = r_busy ? r_clr_addr : ee_addr;
        ram_wdata = r_busy ? emi_pkg::ERASED : r_p1;
    end

    emi_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_cmd),
        .i_raddr (ee_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index    <= '0;
            r_ctl      <= '0;
            r_opc      <= '0;
            r_p0       <= '0;
            r_p1       <= '0;
            r_ret      <= '0;
            r_bank     <= '0;
            r_rd_pend  <= 1'b0;
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_index    <= n_index;
            r_ctl      <= n_ctl;
            r_opc      <= n_opc;
            r_p0       <= n_p0;
            r_p1       <= n_p1;
            r_ret      <= n_ret;
            r_bank     <= n_bank;
            r_rd_pend  <= n_rd_pend;
            r_busy     <= n_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    assign o_busy = r_busy;

    a_no_access_while_erasing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_acc.valid)
        else $error("access taken during erase pass");

    a_bank_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, 8'(r_bank)} < BANK_LIMIT)
        else $error("bank select out of range");

    a_read_pending_from_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> $past(rd_cmd))
        else $error("EEPROM read pending without read command");

    a_start_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(start) |-> !r_ctl[emi_pkg::CTL_START_BIT])
        else $error("START left set after command");

endmodule

`default_nettype wire

// ===== design/eeprom_mailbox_index_io.sv =====
// ----------------------------------------------------------------------------
// eeprom_mailbox_index_io
// Device side of an EEPROM mailbox reached through an index I/O window.
//
// i_in carries one host bus access per word (op, io_port, write_data); o_out
// returns one word per access (read_data, port_selected, command_done).
// Index ports set a 16-bit RAM index, the data port reads or writes the
// mailbox byte it points at, and a control write with START runs the opcode.
// Configuration registers are written via i_cfg_we/i_cfg_index/i_cfg_data;
// the user must keep this to times when no access is in flight (unchecked).
//
// An access is decoded and executed in the cycle it is accepted; its result
// sits in the output register in the cycle after. One access per cycle is
// sustained while no erase pass runs and the output register is taken.
// After reset all BANK_COUNT * BYTES_PER_BANK bytes (2048 by default) of the
// EEPROM array are erased to 0xFF, one byte per cycle, with i_in.ready low.
// When the receiver stalls, the result holds and i_in.ready drops until the
// output register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module eeprom_mailbox_index_io #(
    parameter int BANK_COUNT     = emi_pkg::BANK_COUNT_DEF,
    parameter int BYTES_PER_BANK = emi_pkg::BYTES_PER_BANK_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    emi_in_if.sink           i_in,
    emi_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    emi_pkg::t_cfg      r_cfg;
    emi_pkg::t_port_sel port;
    emi_pkg::t_access   acc;
    emi_pkg::t_mbx_resp resp;
    logic               busy;
    logic               accept;

    logic       r_out_valid, n_out_valid;
    logic [7:0] r_rdata;
    logic       r_sel;
    logic       r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_base <= emi_pkg::RST_WINDOW_BASE;
            r_cfg.high_offset <= emi_pkg::RST_HIGH_OFFSET;
            r_cfg.low_offset  <= emi_pkg::RST_LOW_OFFSET;
            r_cfg.data_offset <= emi_pkg::RST_DATA_OFFSET;
            r_cfg.ctl_addr    <= emi_pkg::RST_CTL_ADDR;
            r_cfg.opc_addr    <= emi_pkg::RST_OPC_ADDR;
            r_cfg.param_addr  <= emi_pkg::RST_PARAM_ADDR;
            r_cfg.ret_addr    <= emi_pkg::RST_RET_ADDR;
        end else if (i_cfg_we) begin
            case (emi_pkg::t_cfg_idx'(i_cfg_index))
                emi_pkg::REG_WINDOW_BASE: r_cfg.window_base <= i_cfg_data;
                emi_pkg::REG_HIGH_OFFSET: r_cfg.high_offset <= i_cfg_data[2:0];
                emi_pkg::REG_LOW_OFFSET:  r_cfg.low_offset  <= i_cfg_data[2:0];
                emi_pkg::REG_DATA_OFFSET: r_cfg.data_offset <= i_cfg_data[2:0];
                emi_pkg::REG_CTL_ADDR:    r_cfg.ctl_addr    <= i_cfg_data;
                emi_pkg::REG_OPC_ADDR:    r_cfg.opc_addr    <= i_cfg_data;
                emi_pkg::REG_PARAM_ADDR:  r_cfg.param_addr  <= i_cfg_data;
                emi_pkg::REG_RET_ADDR:    r_cfg.ret_addr    <= i_cfg_data;
                default:                  r_cfg             <= r_cfg;
            endcase
        end
    end

    assign i_in.ready = !busy && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    emi_decode u_decode (
        .i_cfg     (r_cfg),
        .i_io_port (i_in.io_port),
        .o_port    (port)
    );

    always_comb begin
        acc.valid   = accept;
        acc.is_read = i_in.op;
        acc.port    = port;
        acc.wdata   = i_in.write_data;
    end

    emi_mailbox #(
        .BANK_COUNT     (BANK_COUNT),
        .BYTES_PER_BANK (BYTES_PER_BANK)
    ) u_mailbox (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_acc   (acc),
        .o_resp  (resp),
        .o_busy  (busy)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= resp.rdata;
            r_sel   <= (port != emi_pkg::PORT_NONE);
            r_done  <= resp.done;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.read_data     = r_rdata;
    assign o_out.port_selected = r_sel;
    assign o_out.command_done  = r_done;

    a_accept_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted word produced no result");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input ready while result stalled");

    a_done_needs_data_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && resp.done) |-> (port == emi_pkg::PORT_DATA && !i_in.op))
        else $error("command done outside a data port write");

endmodule

`default_nettype wire
